/* src/bsa_pkg.sv */
// shared types and constants for the buddy split allocator
// used by the rtl (bsa_cell, buddy_split_allocator_unit) and the testbench
package bsa_pkg;

  localparam int ORDER_W = 5;
  localparam int OWNER_W = 16;
  localparam int SIZE_W = 31;
  localparam int LEN_W = 7;
  localparam int STATUS_W = 2;

  localparam int MAX_BLOCKS_DEF = 64;
  localparam int ID_BITS_DEF = 16;
  localparam logic [ORDER_W-1:0] ORDER_RESET = 5'd10;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVER = 2'd2;

  localparam logic [2:0] CMD_HOLD = 3'd0;
  localparam logic [2:0] CMD_ROT = 3'd1;
  localparam logic [2:0] CMD_SPLIT = 3'd2;
  localparam logic [2:0] CMD_SET = 3'd3;
  localparam logic [2:0] CMD_INIT = 3'd4;

  typedef struct packed {
    logic [2:0] cmd;
    logic [ORDER_W-1:0] init_order;
  } cell_ctl_t;

endpackage

/* src/bsa_cell.sv */
// one list entry of the allocator chain: block order and owner
// depends on bsa_pkg for the command codes and control struct
module bsa_cell #(
  parameter int IDX = 0,
  parameter int ID_BITS = bsa_pkg::ID_BITS_DEF
) (
  input  logic                          clk,
  input  bsa_pkg::cell_ctl_t            ctl,
  input  logic                          wrap,
  input  logic [bsa_pkg::ORDER_W-1:0]   up_order,
  input  logic [ID_BITS-1:0]            up_owner,
  input  logic [bsa_pkg::ORDER_W-1:0]   dn_order,
  input  logic [ID_BITS-1:0]            dn_owner,
  input  logic [bsa_pkg::ORDER_W-1:0]   head_order,
  input  logic [ID_BITS-1:0]            head_owner,
  input  logic [ID_BITS-1:0]            new_owner,
  output logic [bsa_pkg::ORDER_W-1:0]   order,
  output logic [ID_BITS-1:0]            owner
);

  always_ff @(posedge clk) begin
    case (ctl.cmd)
      bsa_pkg::CMD_ROT: begin
        if (wrap) begin
          order <= head_order;
          owner <= head_owner;
        end else begin
          order <= up_order;
          owner <= up_owner;
        end
      end
      bsa_pkg::CMD_SPLIT: begin
        if (IDX == 0) begin
          order <= order - 1'b1;
        end else if (IDX == 1) begin
          order <= head_order - 1'b1;
          owner <= '0;
        end else begin
          order <= dn_order;
          owner <= dn_owner;
        end
      end
      bsa_pkg::CMD_SET: begin
        if (IDX == 0) begin
          owner <= new_owner;
        end
      end
      bsa_pkg::CMD_INIT: begin
        if (IDX == 0) begin
          order <= ctl.init_order;
          owner <= '0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* src/buddy_split_allocator_unit.sv */
// top level of the buddy split allocator: sequencer plus a ring of list cells
// depends on bsa_pkg and bsa_cell
//
// input channel (in_valid/in_stall, opcode, owner_id, request_size) takes one
// transaction at a time; in_stall is high while a transaction is in work.
// output channel (out_valid/out_stall) carries the results through one
// output register, so the sequencer may finish while a result waits.
// the list lives in a ring of cells ordered from the list end; the head cell
// is the only one examined, and the ring rotates one place per cycle.
// allocate: find the order of the request, then rotate the ring past each entry
// that does not fit, split the found block, then rotations that restore the ring;
// one result with last set.
// query: one result per list entry, one per cycle while out_stall is low;
// a stalled output freezes the ring.
// reset (and a write of cfg_wdata) leaves one free block of the given order,
// order 10 after reset; config writes belong only to idle periods.
module buddy_split_allocator_unit #(
  parameter int MAX_BLOCKS = bsa_pkg::MAX_BLOCKS_DEF,
  parameter int ID_BITS = bsa_pkg::ID_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bsa_pkg::ORDER_W-1:0]    cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           opcode,
  input  logic [bsa_pkg::OWNER_W-1:0]    owner_id,
  input  logic [bsa_pkg::SIZE_W-1:0]     request_size,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bsa_pkg::OWNER_W-1:0]    owner_out,
  output logic [bsa_pkg::LEN_W-1:0]      list_length,
  output logic [bsa_pkg::STATUS_W-1:0]   status,
  output logic                           last
);

  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int SUM_W = CNT_W + 6;
  localparam int OW = (ID_BITS < bsa_pkg::OWNER_W) ? ID_BITS : bsa_pkg::OWNER_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ORD = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_SPLIT = 3'd3;
  localparam logic [2:0] S_UNROT = 3'd4;
  localparam logic [2:0] S_RESP = 3'd5;
  localparam logic [2:0] S_QRY = 3'd6;

  logic [2:0] state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] rot;
  logic [CNT_W-1:0] rem;
  logic [CNT_W-1:0] qn;
  logic [bsa_pkg::ORDER_W-1:0] k;
  logic [bsa_pkg::SIZE_W-1:0] sreg;
  logic [ID_BITS-1:0] owner_q;
  logic [bsa_pkg::STATUS_W-1:0] status_q;

  logic [bsa_pkg::ORDER_W-1:0] ord [MAX_BLOCKS];
  logic [ID_BITS-1:0] own [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] wrap;
  bsa_pkg::cell_ctl_t ctl;

  logic can_load;
  logic fit;
  logic over;
  logic in_acc;

  assign in_stall = (state != S_IDLE);
  assign in_acc = in_valid && !in_stall;
  assign can_load = !out_valid || !out_stall;
  assign fit = (own[0] == '0) && (ord[0] >= k);
  assign over = (SUM_W'(count) + SUM_W'(ord[0] - k)) > SUM_W'(MAX_BLOCKS);

  always_comb begin
    ctl.cmd = bsa_pkg::CMD_HOLD;
    ctl.init_order = cfg_wdata;
    if (rst) begin
      ctl.cmd = bsa_pkg::CMD_INIT;
      ctl.init_order = bsa_pkg::ORDER_RESET;
    end else if (cfg_we) begin
      ctl.cmd = bsa_pkg::CMD_INIT;
    end else begin
      case (state)
        S_SCAN: begin
          if (rot != count && !fit) begin
            ctl.cmd = bsa_pkg::CMD_ROT;
          end
        end
        S_SPLIT: begin
          if (ord[0] > k) begin
            ctl.cmd = bsa_pkg::CMD_SPLIT;
          end else begin
            ctl.cmd = bsa_pkg::CMD_SET;
          end
        end
        S_UNROT: ctl.cmd = bsa_pkg::CMD_ROT;
        S_QRY: begin
          if (can_load) begin
            ctl.cmd = bsa_pkg::CMD_ROT;
          end
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    logic [bsa_pkg::ORDER_W-1:0] up_o;
    logic [ID_BITS-1:0] up_w;
    logic [bsa_pkg::ORDER_W-1:0] dn_o;
    logic [ID_BITS-1:0] dn_w;

    assign wrap[i] = (CNT_W'(i) == count - 1'b1);

    if (i == MAX_BLOCKS - 1) begin : g_top
      assign up_o = '0;
      assign up_w = '0;
    end else begin : g_mid
      assign up_o = ord[i+1];
      assign up_w = own[i+1];
    end

    if (i == 0) begin : g_bot
      assign dn_o = '0;
      assign dn_w = '0;
    end else begin : g_nb
      assign dn_o = ord[i-1];
      assign dn_w = own[i-1];
    end

    bsa_cell #(
      .IDX(i),
      .ID_BITS(ID_BITS)
    ) u_cell (
      .clk(clk),
      .ctl(ctl),
      .wrap(wrap[i]),
      .up_order(up_o),
      .up_owner(up_w),
      .dn_order(dn_o),
      .dn_owner(dn_w),
      .head_order(ord[0]),
      .head_owner(own[0]),
      .new_owner(owner_q),
      .order(ord[i]),
      .owner(own[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= CNT_W'(1);
      out_valid <= 1'b0;
    end else begin
      if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        count <= CNT_W'(1);
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            state <= (opcode == bsa_pkg::OP_QUERY) ? S_QRY : S_ORD;
          end
        end
        S_ORD: begin
          if (sreg == '0) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rot == count) begin
            state <= S_RESP;
          end else if (fit) begin
            if (over) begin
              state <= (rot == '0) ? S_RESP : S_UNROT;
            end else begin
              state <= S_SPLIT;
            end
          end
        end
        S_SPLIT: begin
          if (ord[0] > k) begin
            count <= count + 1'b1;
          end else begin
            state <= (rot == '0) ? S_RESP : S_UNROT;
          end
        end
        S_UNROT: begin
          if (rem == CNT_W'(1)) begin
            state <= S_RESP;
          end
        end
        S_RESP: begin
          if (can_load) begin
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_QRY: begin
          if (can_load) begin
            out_valid <= 1'b1;
            if (qn == CNT_W'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          owner_q <= ID_BITS'(owner_id[OW-1:0]);
          sreg <= (request_size == '0) ? '0 : request_size - 1'b1;
          k <= '0;
          rot <= '0;
          qn <= count;
          status_q <= bsa_pkg::ST_OK;
        end
      end
      S_ORD: begin
        if (sreg != '0) begin
          sreg <= sreg >> 1;
          k <= k + 1'b1;
        end
      end
      S_SCAN: begin
        if (rot == count) begin
          status_q <= bsa_pkg::ST_NOFIT;
        end else if (fit) begin
          if (over) begin
            status_q <= bsa_pkg::ST_OVER;
            rem <= count - rot;
          end
        end else begin
          rot <= rot + 1'b1;
        end
      end
      S_SPLIT: begin
        if (!(ord[0] > k)) begin
          rem <= count - rot;
        end
      end
      S_UNROT: rem <= rem - 1'b1;
      S_RESP: begin
        if (can_load) begin
          owner_out <= '0;
          list_length <= bsa_pkg::LEN_W'(count);
          status <= status_q;
          last <= 1'b1;
        end
      end
      S_QRY: begin
        if (can_load) begin
          owner_out <= bsa_pkg::OWNER_W'(own[0][OW-1:0]);
          list_length <= bsa_pkg::LEN_W'(count);
          status <= bsa_pkg::ST_OK;
          last <= (qn == CNT_W'(1));
          qn <= qn - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* tb/sv/buddy_split_allocator_unit_tb.sv */
// self-checking testbench for buddy_split_allocator_unit: a directed table, then random phases
// under bursty input and a stalling output, checked against an in-file model of the block list
// depends on bsa_pkg and the buddy_split_allocator_unit rtl
module buddy_split_allocator_unit_tb;

  localparam logic OP_ALLOC = bsa_pkg::OP_ALLOC;
  localparam logic OP_QUERY = bsa_pkg::OP_QUERY;
  localparam logic [bsa_pkg::STATUS_W-1:0] ST_OK = bsa_pkg::ST_OK;
  localparam logic [bsa_pkg::STATUS_W-1:0] ST_NOFIT = bsa_pkg::ST_NOFIT;
  localparam logic [bsa_pkg::STATUS_W-1:0] ST_OVER = bsa_pkg::ST_OVER;
  localparam int ORDER_W = bsa_pkg::ORDER_W;
  localparam int OWNER_W = bsa_pkg::OWNER_W;
  localparam int SIZE_W = bsa_pkg::SIZE_W;
  localparam int LEN_W = bsa_pkg::LEN_W;
  localparam int STATUS_W = bsa_pkg::STATUS_W;
  localparam int MAX_BLOCKS = bsa_pkg::MAX_BLOCKS_DEF;
  localparam int ORDER_LIMIT = 31;
  localparam int DRAIN_CYCLES = 2 * MAX_BLOCKS + 64;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 150;
  localparam int PLAN_ROWS = 23;

  typedef struct packed {
    logic [OWNER_W-1:0] owner;
    logic [LEN_W-1:0] len;
    logic [STATUS_W-1:0] status;
    logic last;
  } result_t;

  typedef struct packed {
    logic set_order;
    logic [ORDER_W-1:0] order_val;
    logic op;
    logic [OWNER_W-1:0] owner;
    logic [SIZE_W-1:0] size;
    logic fixed;
    result_t want;
  } plan_row_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [ORDER_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic opcode = OP_ALLOC;
  logic [OWNER_W-1:0] owner_id = '0;
  logic [SIZE_W-1:0] request_size = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [OWNER_W-1:0] owner_out;
  logic [LEN_W-1:0] list_length;
  logic [STATUS_W-1:0] status;
  logic last;

  logic [ORDER_W-1:0] blk_order [MAX_BLOCKS];
  logic [OWNER_W-1:0] blk_owner [MAX_BLOCKS];
  logic [LEN_W-1:0] blk_count;
  result_t pending_results [$];
  int mismatches = 0;
  int burst_left = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  int stall_mode = 0;

  buddy_split_allocator_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .owner_id(owner_id),
    .request_size(request_size),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .owner_out(owner_out),
    .list_length(list_length),
    .status(status),
    .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int size_order(logic [SIZE_W-1:0] size);
    int k = 0;
    while (k < ORDER_LIMIT && (64'd1 << k) < 64'(size)) k++;
    return k;
  endfunction

  function automatic void reset_list(logic [ORDER_W-1:0] ord);
    blk_order[0] = ord;
    blk_owner[0] = '0;
    blk_count = 7'd1;
  endfunction

  function automatic void buddy_step(logic op, logic [OWNER_W-1:0] owner,
                                     logic [SIZE_W-1:0] size);
    int k;
    int pos;
    int splits;
    bit found;
    logic [STATUS_W-1:0] st;
    if (op == OP_QUERY) begin
      for (int j = int'(blk_count) - 1; j >= 0; j--)
        pending_results.push_back('{blk_owner[j], blk_count, ST_OK, j == 0});
    end else begin
      k = size_order(size);
      found = 1'b0;
      pos = 0;
      st = ST_OK;
      for (int i = int'(blk_count) - 1; i >= 0 && !found; i--)
        if (blk_owner[i] == '0 && int'(blk_order[i]) >= k) begin
          found = 1'b1;
          pos = i;
        end
      if (!found) begin
        st = ST_NOFIT;
      end else begin
        splits = int'(blk_order[pos]) - k;
        if (int'(blk_count) + splits > MAX_BLOCKS) begin
          st = ST_OVER;
        end else begin
          // halve in place, keep working on the upper half
          repeat (splits) begin
            for (int j = int'(blk_count); j > pos + 1; j--) begin
              blk_order[j] = blk_order[j-1];
              blk_owner[j] = blk_owner[j-1];
            end
            blk_order[pos] = blk_order[pos] - 5'd1;
            blk_order[pos+1] = blk_order[pos];
            blk_owner[pos+1] = '0;
            blk_count++;
            pos++;
          end
          blk_owner[pos] = owner;
        end
      end
      pending_results.push_back('{'0, blk_count, st, 1'b1});
    end
  endfunction

  function automatic plan_row_t plan_row(logic set_order, logic [ORDER_W-1:0] order_val,
                                         logic op, logic [OWNER_W-1:0] owner,
                                         logic [SIZE_W-1:0] size, logic fixed,
                                         logic [OWNER_W-1:0] want_owner,
                                         logic [LEN_W-1:0] want_len,
                                         logic [STATUS_W-1:0] want_status);
    plan_row_t r;
    r.set_order = set_order;
    r.order_val = order_val;
    r.op = op;
    r.owner = owner;
    r.size = size;
    r.fixed = fixed;
    r.want = '{want_owner, want_len, want_status, 1'b1};
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic send_item(logic op, logic [OWNER_W-1:0] owner, logic [SIZE_W-1:0] size,
                           logic fixed, result_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    opcode <= op;
    owner_id <= owner;
    request_size <= size;
    do @(posedge clk); while (in_stall);
    buddy_step(op, owner, size);
    if (fixed) begin
      void'(pending_results.pop_back());
      pending_results.push_back(want);
    end
  endtask

  task automatic load_order(logic [ORDER_W-1:0] ord);
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= ord;
    @(posedge clk);
    cfg_we <= 1'b0;
    reset_list(ord);
  endtask

  task automatic send_random(logic [ORDER_W-1:0] ord, bit fill);
    logic op;
    logic [OWNER_W-1:0] owner;
    logic [SIZE_W-1:0] size;
    int k;
    result_t none;
    op = ($urandom_range(0, 99) < (fill ? 8 : 15)) ? OP_QUERY : OP_ALLOC;
    owner = ($urandom_range(0, 15) == 0) ? '0 : OWNER_W'($urandom_range(1, 16'hFFFF));
    // fill phases use mostly unit sizes to fragment the list up to overflow
    if (fill) k = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
    else k = $urandom_range(0, (int'(ord) < ORDER_LIMIT) ? int'(ord) + 1 : ORDER_LIMIT);
    if (!fill && $urandom_range(0, 7) == 0)
      size = SIZE_W'($urandom);
    else if (k == 0)
      size = SIZE_W'($urandom_range(0, 1));
    else
      size = SIZE_W'($urandom_range((k == ORDER_LIMIT) ? 32'h7FFF_FFFF : (32'd1 << k),
                                    (32'd1 << (k - 1)) + 32'd1));
    none = '0;
    send_item(op, owner, size, 1'b0, none);
  endtask

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(16, 160);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= 1'($urandom_range(0, 1));
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transaction, owner_out", owner_out, 0);
      end else begin
        want = pending_results.pop_front();
        if (owner_out !== want.owner) report_mismatch("owner_out", owner_out, want.owner);
        if (list_length !== want.len) report_mismatch("list_length", list_length, want.len);
        if (status !== want.status) report_mismatch("status", status, want.status);
        if (last !== want.last) report_mismatch("last", last, want.last);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    plan_row_t plan [PLAN_ROWS];
    int sent;
    int phase_len;
    logic [ORDER_W-1:0] ord;
    plan = '{
      plan_row(0, 0,  OP_QUERY, 16'h0000, 31'd1,          1, 16'h0000, 7'd1,  ST_OK),
      plan_row(0, 0,  OP_ALLOC, 16'hFFFF, 31'd1,          1, 16'h0000, 7'd11, ST_OK),
      plan_row(0, 0,  OP_ALLOC, 16'h0001, 31'h7FFF_FFFF,  1, 16'h0000, 7'd11, ST_NOFIT),
      plan_row(0, 0,  OP_ALLOC, 16'h0002, 31'd1024,       1, 16'h0000, 7'd11, ST_NOFIT),
      plan_row(0, 0,  OP_ALLOC, 16'h0000, 31'd3,          0, 16'h0000, 7'd0,  ST_OK),
      plan_row(0, 0,  OP_ALLOC, 16'h5A5A, 31'd0,          0, 16'h0000, 7'd0,  ST_OK),
      plan_row(0, 0,  OP_ALLOC, 16'hA5A5, 31'h4000_0000,  1, 16'h0000, 7'd11, ST_NOFIT),
      plan_row(0, 0,  OP_QUERY, 16'h1111, 31'd5,          0, 16'h0000, 7'd0,  ST_OK),
      plan_row(1, 0,  OP_ALLOC, 16'h0003, 31'd1,          1, 16'h0000, 7'd1,  ST_OK),
      plan_row(0, 0,  OP_ALLOC, 16'h0004, 31'd1,          1, 16'h0000, 7'd1,  ST_NOFIT),
      plan_row(0, 0,  OP_QUERY, 16'h0000, 31'd0,          1, 16'h0003, 7'd1,  ST_OK),
      plan_row(1, 31, OP_ALLOC, 16'h8001, 31'h7FFF_FFFF,  1, 16'h0000, 7'd1,  ST_OK),
      plan_row(0, 0,  OP_QUERY, 16'hFFFF, 31'h7FFF_FFFF,  1, 16'h8001, 7'd1,  ST_OK),
      plan_row(1, 31, OP_ALLOC, 16'h7FFE, 31'd1,          1, 16'h0000, 7'd32, ST_OK),
      plan_row(0, 0,  OP_ALLOC, 16'h1234, 31'h4000_0000,  1, 16'h0000, 7'd32, ST_OK),
      plan_row(0, 0,  OP_ALLOC, 16'h0F0F, 31'h7FFF_FFFF,  1, 16'h0000, 7'd32, ST_NOFIT),
      plan_row(0, 0,  OP_ALLOC, 16'hF0F0, 31'h2AAA_AAAA,  0, 16'h0000, 7'd0,  ST_OK),
      plan_row(0, 0,  OP_ALLOC, 16'h3C3C, 31'h5555_5555,  0, 16'h0000, 7'd0,  ST_OK),
      plan_row(0, 0,  OP_QUERY, 16'h0000, 31'd0,          0, 16'h0000, 7'd0,  ST_OK),
      plan_row(1, 30, OP_ALLOC, 16'h00FF, 31'h2000_0001,  1, 16'h0000, 7'd1,  ST_OK),
      plan_row(1, 5,  OP_ALLOC, 16'hFF00, 31'd33,         1, 16'h0000, 7'd1,  ST_NOFIT),
      plan_row(0, 0,  OP_ALLOC, 16'hFF00, 31'd32,         1, 16'h0000, 7'd1,  ST_OK),
      plan_row(0, 0,  OP_QUERY, 16'h0000, 31'd0,          1, 16'hFF00, 7'd1,  ST_OK)
    };
    reset_list(bsa_pkg::ORDER_RESET);
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].set_order) load_order(plan[i].order_val);
      send_item(plan[i].op, plan[i].owner, plan[i].size, plan[i].fixed, plan[i].want);
    end

    load_order(5'd31);
    repeat (50) send_random(5'd31, 1'b1);
    sent = 50;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0: ord = 5'd0;
        1: ord = 5'd31;
        default: ord = ORDER_W'($urandom_range(0, 31));
      endcase
      load_order(ord);
      phase_len = $urandom_range(10, 30);
      repeat (phase_len) send_random(ord, 1'b0);
      sent += phase_len;
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
